/* hw/rtl/spfc_pkg.sv */
// ----------------------------------------------------------------------------
// spfc_pkg
// Shared types and constants for the sample packet framer with CRC-32.
// ----------------------------------------------------------------------------
package spfc_pkg;

  // CRC-32, non-reflected, no final inversion
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Item function codes
  localparam logic FUNC_OPEN = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // Tag above the three packed samples of a data word
  localparam logic [1:0] SAMPLE_TAG = 2'b11;

  // Word kinds on the output stream
  localparam logic [2:0] KIND_MAGIC     = 3'd0;
  localparam logic [2:0] KIND_LENGTH    = 3'd1;
  localparam logic [2:0] KIND_HEAD_CRC  = 3'd2;
  localparam logic [2:0] KIND_DATA      = 3'd3;
  localparam logic [2:0] KIND_FINAL_CRC = 3'd4;

  // One word of the packet stream
  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  word_kind;
    logic        packet_end;
  } spfc_word_t;

endpackage

/* hw/rtl/spfc_item_if.sv */
// ----------------------------------------------------------------------------
// spfc_item_if
// Input channel: one open command or one sample triple per word.
// ----------------------------------------------------------------------------
interface spfc_item_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] word_count;
  logic [9:0]  sample_first;
  logic [9:0]  sample_second;
  logic [9:0]  sample_third;

  modport source (
    output valid, func, word_count, sample_first, sample_second, sample_third,
    input  ready
  );

  modport sink (
    input  valid, func, word_count, sample_first, sample_second, sample_third,
    output ready
  );
endinterface

/* hw/rtl/spfc_word_if.sv */
// ----------------------------------------------------------------------------
// spfc_word_if
// Output channel: one 32-bit packet stream word with its kind and end flag.
// ----------------------------------------------------------------------------
interface spfc_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic [2:0]  word_kind;
  logic        packet_end;

  modport source (
    output valid, out_word, word_kind, packet_end,
    input  ready
  );

  modport sink (
    input  valid, out_word, word_kind, packet_end,
    output ready
  );
endinterface

/* hw/rtl/spfc_crc_step.sv */
// ----------------------------------------------------------------------------
// spfc_crc_step
// Parallel CRC-32 update over one 32-bit word, fed with its halfwords swapped.
// ----------------------------------------------------------------------------
module spfc_crc_step
  import spfc_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [31:0] data_word,
  output logic [31:0] crc_out
);

  logic [31:0] swapped;

  assign swapped = {data_word[15:0], data_word[31:16]};

  // Fold the word in MSB first; flattens to an XOR network
  always_comb begin
    logic [31:0] acc;
    logic        top;
    acc = crc_in;
    for (int b = 31; b >= 0; b--) begin
      top = acc[31] ^ swapped[b];
      acc = {acc[30:0], 1'b0};
      if (top) begin
        acc = acc ^ CRC_POLY;
      end
    end
    crc_out = acc;
  end

endmodule

/* hw/rtl/spfc_sequencer.sv */
// ----------------------------------------------------------------------------
// spfc_sequencer
// Holds one input word and walks it through its packet words, one per cycle
// while adv is high, updating the running CRC, packet counter and remaining data word count.
// ----------------------------------------------------------------------------
module spfc_sequencer
  import spfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  spfc_item_if.sink    items,
  input  logic         adv,
  output spfc_word_t   word,
  output logic         word_valid
);

  // Step through the words one item produces
  localparam logic [1:0] STEP_WORD0 = 2'd0;
  localparam logic [1:0] STEP_WORD1 = 2'd1;
  localparam logic [1:0] STEP_WORD2 = 2'd2;
  localparam logic [1:0] STEP_WORD3 = 2'd3;

  logic [31:0] magic;
  logic        cur_valid;
  logic        cur_func;
  logic [15:0] cur_count;
  logic [31:0] cur_data;
  logic [1:0]  step;
  logic [31:0] crc;
  logic [15:0] packet_number;
  logic [15:0] words_left;
  logic        packet_open;

  logic        drop;
  logic        fire;
  logic        last;
  logic        feed;
  logic        done;
  logic        take;
  logic [31:0] crc_seed;
  logic [31:0] crc_next;

  // Data outside an open packet is consumed without output; only judged on
  // the first step, as the last data word closes the packet before its CRC
  assign drop       = cur_valid && (cur_func == FUNC_DATA) && (step == STEP_WORD0) &&
                      !packet_open;
  assign word_valid = cur_valid && !drop;
  assign fire       = word_valid && adv;
  assign done       = drop || (fire && last);
  assign take       = items.valid && items.ready;
  assign items.ready = !cur_valid || done;

  // Select the word for the current step
  always_comb begin
    word     = '0;
    last     = 1'b0;
    feed     = 1'b0;
    crc_seed = crc;
    if (cur_func == FUNC_OPEN) begin
      unique case (step)
        STEP_WORD0: begin
          word.out_word  = magic;
          word.word_kind = KIND_MAGIC;
          feed           = 1'b1;
          crc_seed       = CRC_INIT;
        end
        STEP_WORD1: begin
          word.out_word  = {cur_count, packet_number};
          word.word_kind = KIND_LENGTH;
          feed           = 1'b1;
        end
        STEP_WORD2: begin
          word.out_word  = crc;
          word.word_kind = KIND_HEAD_CRC;
          feed           = 1'b1;
          last           = (cur_count != 16'd0);
        end
        STEP_WORD3: begin
          word.out_word   = crc;
          word.word_kind  = KIND_FINAL_CRC;
          word.packet_end = 1'b1;
          last            = 1'b1;
        end
        default: begin
          word = '0;
        end
      endcase
    end else begin
      priority if (step == STEP_WORD0) begin
        word.out_word  = cur_data;
        word.word_kind = KIND_DATA;
        feed           = 1'b1;
        last           = (words_left != 16'd1);
      end else begin
        word.out_word   = crc;
        word.word_kind  = KIND_FINAL_CRC;
        word.packet_end = 1'b1;
        last            = 1'b1;
      end
    end
  end

  spfc_crc_step u_crc (
    .crc_in    (crc_seed),
    .data_word (word.out_word),
    .crc_out   (crc_next)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      magic <= '0;
    end else if (cfg_wr_en) begin
      magic <= cfg_wr_data;
    end
  end

  // Hold the current input word and advance its step
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= STEP_WORD0;
    end else begin
      if (take) begin
        cur_valid <= 1'b1;
        step      <= STEP_WORD0;
      end else if (done) begin
        cur_valid <= 1'b0;
        step      <= STEP_WORD0;
      end else if (fire) begin
        step <= step + 2'd1;
      end
    end
  end

  // Payload of the held word
  always_ff @(posedge clk) begin
    if (take) begin
      cur_func  <= items.func;
      cur_count <= items.word_count;
      cur_data  <= {SAMPLE_TAG, items.sample_first, items.sample_second,
                    items.sample_third};
    end
  end

  // Packet state: CRC, counter and remaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= CRC_INIT;
      packet_number <= '0;
      words_left    <= '0;
      packet_open   <= 1'b0;
    end else if (fire) begin
      if (feed) begin
        crc <= crc_next;
      end
      if (cur_func == FUNC_OPEN) begin
        if (step == STEP_WORD1) begin
          packet_number <= packet_number + 16'd1;
        end
        if (step == STEP_WORD2) begin
          words_left  <= cur_count;
          packet_open <= (cur_count != 16'd0);
        end
      end else if (step == STEP_WORD0) begin
        words_left <= words_left - 16'd1;
        if (words_left == 16'd1) begin
          packet_open <= 1'b0;
        end
      end
    end
  end

endmodule

/* hw/rtl/sample_packet_framer_crc32.sv */
// ----------------------------------------------------------------------------
// sample_packet_framer_crc32
// Frames sample triples into 32-bit packet words with a running CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   items  : valid/ready input. func = open carries word_count and starts a
//            packet; func = data carries three 10-bit samples.
//   words  : valid/ready output, one packet word per transfer with its kind
//            and an end flag on the final CRC word.
//   cfg_wr_en/cfg_wr_data : write the magic word; write only while idle.
// Path: an accepted item is held in the sequencer's holding register, and each
//   of its words is registered in the output register before it is presented.
// Throughput: one output word per cycle at most, and only while words.ready is
//   high. An open item yields 3 words (4 for an empty packet), a data word 1
//   word (2 for the last of a packet), and a data word outside a packet is
//   consumed with no output. The single output register holds one word.
// Reset: CRC goes to all ones, packet counter and open state clear, the
//   magic word reads zero and no word is presented.
// Stall: while words.ready is low the output word holds; an input word is
//   still taken only if the holding register is empty, then items.ready drops.
//   Data words outside a packet keep being taken and dropped meanwhile.
// ----------------------------------------------------------------------------
module sample_packet_framer_crc32
  import spfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  spfc_item_if.sink    items,
  spfc_word_if.source  words
);

  spfc_word_t seq_word;
  logic       seq_valid;
  logic       adv;
  logic       out_valid;
  spfc_word_t out_q;

  // Output register moves when empty or being taken
  assign adv = !out_valid || words.ready;

  spfc_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (items),
    .adv         (adv),
    .word        (seq_word),
    .word_valid  (seq_valid)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= seq_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv && seq_valid) begin
      out_q <= seq_word;
    end
  end

  assign words.valid      = out_valid;
  assign words.out_word   = out_q.out_word;
  assign words.word_kind  = out_q.word_kind;
  assign words.packet_end = out_q.packet_end;

  // Nothing presented straight after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !words.valid)
    else $error("output word presented after reset");

  // End flag marks exactly the final CRC word
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    words.valid |-> (words.packet_end == (words.word_kind == KIND_FINAL_CRC)))
    else $error("packet end flag does not match final CRC kind");

  // Data words carry the sample tag
  a_data_tag: assert property (@(posedge clk) disable iff (rst)
    (words.valid && (words.word_kind == KIND_DATA)) |->
      (words.out_word[31:30] == SAMPLE_TAG))
    else $error("data word without sample tag");

endmodule
